// File: rtl/kvos_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kvos_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_LEN_W  = 4;
  localparam int KEY_BITS   = 64;
  localparam int CHAR_W     = 8;
  localparam int COUNT_W    = 8;
  localparam int MATCH_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ONLY = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_EQ    = 8'h3d;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hff;

  typedef struct packed {
    logic [CHAR_W-1:0]  value_byte;
    logic               byte_valid;
    logic               value_done;
    logic               value_truncated;
    logic               line_end;
    logic [COUNT_W-1:0] found_count;
  } kvos_result_t;

endpackage

`default_nettype wire

// File: rtl/key_value_option_scanner_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------
// input    | in_valid / in_ready   | character
// output   | out_valid / out_ready | value_byte, byte_valid, value_done,
//          |                       | value_truncated, line_end, found_count
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; an item that yields a result
// passes from the input register into the result register.
// Synchronous reset returns scanner state, configuration and valid flags to their reset values.
// A stalled result holds the input register; input stalls only when both are full.
// Configuration writes are taken every cycle.

module key_value_option_scanner_unit #(
  parameter int KEY_MAX_CHARS   = 8,
  parameter int VALUE_LEN_WIDTH = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [kvos_pkg::CHAR_W-1:0]      character,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [kvos_pkg::CHAR_W-1:0]           value_byte,
  output logic                                  byte_valid,
  output logic                                  value_done,
  output logic                                  value_truncated,
  output logic                                  line_end,
  output logic [kvos_pkg::COUNT_W-1:0]          found_count,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [kvos_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kvos_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kvos_pkg::*;

  logic [KEY_BITS-1:0]        key_chars;
  logic [KEY_LEN_W-1:0]       key_length;
  logic [VALUE_LEN_WIDTH-1:0] max_value_length;
  logic                       first_only;

  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              advance;
  logic              step;
  logic              res_valid;
  kvos_result_t      res;
  kvos_result_t      out_reg;

  kvos_cfg #(
    .VALUE_LEN_WIDTH(VALUE_LEN_WIDTH)
  ) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .key_chars       (key_chars),
    .key_length      (key_length),
    .max_value_length(max_value_length),
    .first_only      (first_only)
  );

  kvos_core #(
    .KEY_MAX_CHARS  (KEY_MAX_CHARS),
    .VALUE_LEN_WIDTH(VALUE_LEN_WIDTH)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .character       (s1_char),
    .key_chars       (key_chars),
    .key_length      (key_length),
    .max_value_length(max_value_length),
    .first_only      (first_only),
    .res_valid       (res_valid),
    .res             (res)
  );

  assign advance  = !out_valid || out_ready;
  assign step     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char <= character;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_reg <= res;
    end
  end

  assign value_byte      = out_reg.value_byte;
  assign byte_valid      = out_reg.byte_valid;
  assign value_done      = out_reg.value_done;
  assign value_truncated = out_reg.value_truncated;
  assign line_end        = out_reg.line_end;
  assign found_count     = out_reg.found_count;

endmodule

`default_nettype wire

// File: rtl/kvos_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module kvos_cfg #(
  parameter int VALUE_LEN_WIDTH = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [kvos_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kvos_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [kvos_pkg::KEY_BITS-1:0]         key_chars,
  output logic [kvos_pkg::KEY_LEN_W-1:0]        key_length,
  output logic [VALUE_LEN_WIDTH-1:0]            max_value_length,
  output logic                                  first_only
);
  import kvos_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_chars        <= '0;
      key_length       <= KEY_LEN_W'(1);
      max_value_length <= VALUE_LEN_WIDTH'(63);
      first_only       <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_CHARS:  key_chars        <= cfg_data[KEY_BITS-1:0];
        REG_KEY_LENGTH: key_length       <= cfg_data[KEY_LEN_W-1:0];
        REG_MAX_VALUE:  max_value_length <= cfg_data[VALUE_LEN_WIDTH-1:0];
        REG_FIRST_ONLY: first_only       <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/kvos_core.sv
`timescale 1ns / 1ps
`default_nettype none

module kvos_core #(
  parameter int KEY_MAX_CHARS   = 8,
  parameter int VALUE_LEN_WIDTH = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [kvos_pkg::CHAR_W-1:0]   character,
  input  wire logic [kvos_pkg::KEY_BITS-1:0] key_chars,
  input  wire logic [kvos_pkg::KEY_LEN_W-1:0] key_length,
  input  wire logic [VALUE_LEN_WIDTH-1:0]    max_value_length,
  input  wire logic                          first_only,
  output logic                               res_valid,
  output kvos_pkg::kvos_result_t             res
);
  import kvos_pkg::*;

  typedef enum logic [2:0] {
    PH_BLANK,
    PH_MATCH,
    PH_SKIP,
    PH_VALUE,
    PH_STOP
  } phase_t;

  localparam int VL_W = VALUE_LEN_WIDTH + 1;

  phase_t             phase, phase_next;
  logic [MATCH_W-1:0] match_position, match_position_next;
  logic [VL_W-1:0]    value_length, value_length_next;
  logic [COUNT_W-1:0] values_found, values_found_next;

  logic [KEY_LEN_W-1:0] klen;
  logic [MATCH_W-1:0]   pos;
  logic [CHAR_W-1:0]    kbyte;
  logic                 blank;
  logic [VL_W-1:0]      max_ext;
  logic [COUNT_W-1:0]   found_inc;
  phase_t               m_phase;
  logic [MATCH_W-1:0]   m_pos;
  logic                 m_open;

  assign klen = (key_length > KEY_LEN_W'(KEY_MAX_CHARS)) ? KEY_LEN_W'(KEY_MAX_CHARS)
                                                         : key_length;
  assign blank     = (character == CHAR_SPACE) || (character == CHAR_TAB);
  assign max_ext   = {1'b0, max_value_length};
  assign found_inc = (values_found != COUNT_MAX) ? values_found + 1'b1 : values_found;
  assign pos       = (phase == PH_MATCH) ? match_position : '0;
  assign kbyte     = key_chars[pos[2:0]*CHAR_W +: CHAR_W];

  always_comb begin
    m_phase = PH_SKIP;
    m_pos   = pos;
    m_open  = 1'b0;
    if (klen == '0) begin
      m_phase = PH_SKIP;
    end else if (pos < MATCH_W'(klen)) begin
      if (character == kbyte) begin
        m_pos   = pos + 1'b1;
        m_phase = PH_MATCH;
      end
    end else if (character == CHAR_EQ) begin
      m_phase = PH_VALUE;
      m_open  = 1'b1;
    end
  end

  always_comb begin
    phase_next          = phase;
    match_position_next = match_position;
    value_length_next   = value_length;
    values_found_next   = values_found;
    res_valid           = 1'b0;
    res                 = '0;
    res.found_count     = values_found;
    if (character == CHAR_NUL) begin
      res_valid    = 1'b1;
      res.line_end = 1'b1;
      if (phase == PH_VALUE && value_length != '0) begin
        res.value_done      = 1'b1;
        res.value_truncated = value_length > max_ext;
        res.found_count     = found_inc;
      end
      phase_next          = PH_BLANK;
      match_position_next = '0;
      value_length_next   = '0;
      values_found_next   = '0;
    end else begin
      unique case (phase)
        PH_BLANK, PH_MATCH: begin
          if (blank) begin
            phase_next = PH_BLANK;
          end else begin
            phase_next          = m_phase;
            match_position_next = m_pos;
            if (m_open) begin
              value_length_next = '0;
            end
          end
        end
        PH_SKIP: begin
          if (blank) begin
            phase_next = PH_BLANK;
          end
        end
        PH_VALUE: begin
          if (blank) begin
            if (value_length != '0) begin
              res_valid           = 1'b1;
              res.value_done      = 1'b1;
              res.value_truncated = value_length > max_ext;
              res.found_count     = found_inc;
              values_found_next   = found_inc;
              phase_next          = first_only ? PH_STOP : PH_BLANK;
              value_length_next   = '0;
            end else begin
              phase_next = PH_BLANK;
            end
          end else if (value_length < max_ext) begin
            value_length_next = value_length + 1'b1;
            res_valid         = 1'b1;
            res.value_byte    = character;
            res.byte_valid    = 1'b1;
          end else begin
            value_length_next = max_ext + 1'b1;
          end
        end
        PH_STOP: ;
        default: phase_next = PH_BLANK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_BLANK;
      match_position <= '0;
      value_length   <= '0;
      values_found   <= '0;
    end else if (step) begin
      phase          <= phase_next;
      match_position <= match_position_next;
      value_length   <= value_length_next;
      values_found   <= values_found_next;
    end
  end

endmodule

`default_nettype wire
